// ===== rtl/order_statistic_set_core_assert.svh =====
`ifndef ORDER_STATISTIC_SET_CORE_ASSERT_SVH
`define ORDER_STATISTIC_SET_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define OSS_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("order statistic set check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define OSS_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("order statistic set check failed");

`endif

// ===== rtl/oss_pkg.sv =====
package oss_pkg;

    localparam int CAPACITY   = 1024;
    localparam int KEY_BITS   = 32;

    localparam int OP_W       = 2;
    localparam int KEY_IN_W   = 32;
    localparam int RANK_W     = 11;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 11;

    localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);
    localparam int CMP_W      = (RANK_W > CNT_BITS) ? RANK_W : CNT_BITS;

    localparam int RADIX_BITS  = 4;
    localparam int RADIX       = 1 << RADIX_BITS;
    localparam int TREE_LEVELS = (IDX_BITS + RADIX_BITS - 1) / RADIX_BITS;
    localparam int TREE_PAD    = 1 << (RADIX_BITS * TREE_LEVELS);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_DUP    = 3'd1,
        ST_ABSENT = 3'd2,
        ST_FULL   = 3'd3,
        ST_RANK   = 3'd4
    } status_t;

    typedef logic signed [KEY_BITS-1:0] key_t;

    typedef struct packed {
        logic hit;
        key_t qv;
    } node_t;

    typedef struct packed {
        logic                cmp;
        logic                ins;
        logic                del;
        key_t                b;
        logic [IDX_BITS-1:0] tgt;
        logic [CNT_BITS-1:0] cnt;
    } cell_ctl_t;

    function automatic int lvl_off(input int l);
        int s;
        s = 0;
        for (int j = 1; j < l; j++)
        begin
            s = s + (TREE_PAD >> (RADIX_BITS * j));
        end
        return s;
    endfunction

    localparam int TREE_NODES = lvl_off(TREE_LEVELS + 1);

    function automatic key_t key_of(input logic [KEY_IN_W-1:0] d);
        key_t k;
        for (int i = 0; i < KEY_BITS; i++)
        begin
            k[i] = (i < KEY_IN_W) ? d[i % KEY_IN_W] : 1'b0;
        end
        return k;
    endfunction

    function automatic logic signed [VALUE_W-1:0] value_of(input key_t k);
        logic signed [VALUE_W-1:0] v;
        for (int j = 0; j < VALUE_W; j++)
        begin
            v[j] = (j < KEY_BITS) ? k[j % KEY_BITS] : k[KEY_BITS-1];
        end
        return v;
    endfunction

endpackage

// ===== rtl/oss_req_if.sv =====
interface oss_req_if
    import oss_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            op;
    logic signed [KEY_IN_W-1:0] key;
    logic [RANK_W-1:0]          rank;

    modport source (output valid, op, key, rank, input ready);
    modport sink   (input valid, op, key, rank, output ready);
endinterface

// ===== rtl/oss_rsp_if.sv =====
interface oss_rsp_if
    import oss_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        count;

    modport source (output valid, value, status, count, input ready);
    modport sink   (input valid, value, status, count, output ready);
endinterface

// ===== rtl/order_statistic_set_core.sv =====
// Sorted set of up to CAPACITY distinct signed keys held in a row of cells, one key per
// cell in ascending order. Each request (insert, delete or k-th largest query) gives
// exactly one response with a status and the key count after the request. A request
// passes through an accept step, a compare step in which every cell compares its key,
// a wait through the registered 16-way OR tree of TREE_LEVELS levels that gathers the
// match flag and the selected key, and a commit step in which every cell from the
// insert or delete position upward shifts together; commit waits while the output
// register still holds an unread response. The next request is taken while the
// previous response still waits at the output register. No clearing pass follows
// reset; the block is ready at once.
`include "order_statistic_set_core_assert.svh"

module order_statistic_set_core
    import oss_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    oss_req_if.sink   req,
    oss_rsp_if.source rsp
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CMP    = 4'b0010,
        S_WAIT   = 4'b0100,
        S_COMMIT = 4'b1000
    } state_t;

    localparam int WAIT_W = $clog2(TREE_LEVELS + 1);

    state_t              state_reg, state_next;
    logic [WAIT_W-1:0]   wait_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    op_t                 op_reg;
    key_t                b_reg;
    logic [IDX_BITS-1:0] tgt_reg;
    logic                rank_bad_reg;

    logic                      rsp_valid_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [STATUS_W-1:0]       status_reg;
    logic [COUNT_W-1:0]        count_reg;

    logic                in_acc;
    logic [CMP_W-1:0]    cnt_ext, rank_ext, diff;
    logic                commit_go, full;
    logic                commit_ins, commit_del;
    node_t               top;
    cell_ctl_t           ctl;
    status_t             status_next;
    logic signed [VALUE_W-1:0] value_next;

    key_t  key_w  [CAPACITY];
    logic  lt_w   [CAPACITY];
    node_t leaf_w [CAPACITY];

    assign req.ready = (state_reg == S_IDLE);
    assign in_acc    = req.valid && req.ready;

    assign cnt_ext  = CMP_W'(cnt_reg);
    assign rank_ext = CMP_W'(req.rank);
    assign diff     = cnt_ext - rank_ext;

    assign full       = cnt_reg >= CNT_BITS'(CAPACITY);
    assign commit_go  = (state_reg == S_COMMIT) && (!rsp_valid_reg || rsp.ready);
    assign commit_ins = commit_go && (op_reg == OP_INSERT) && !top.hit && !full;
    assign commit_del = commit_go && (op_reg == OP_DELETE) && top.hit;

    assign ctl.cmp = (state_reg == S_CMP);
    assign ctl.ins = commit_ins;
    assign ctl.del = commit_del;
    assign ctl.b   = b_reg;
    assign ctl.tgt = tgt_reg;
    assign ctl.cnt = cnt_reg;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        key_t lk, rk;
        logic llt;
        if (i == 0)
        begin : g_head
            assign lk  = b_reg;
            assign llt = 1'b1;
        end
        else
        begin : g_body
            assign lk  = key_w[i-1];
            assign llt = lt_w[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_tail
            assign rk = key_w[i];
        end
        else
        begin : g_next
            assign rk = key_w[i+1];
        end
        oss_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .idx       (IDX_BITS'(i)),
            .left_key  (lk),
            .left_lt   (llt),
            .right_key (rk),
            .key       (key_w[i]),
            .lt        (lt_w[i]),
            .leaf      (leaf_w[i])
        );
    end

    oss_or_tree u_tree (
        .clk    (clk),
        .leaves (leaf_w),
        .top    (top)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_acc) state_next = S_CMP;
            S_CMP:    state_next = S_WAIT;
            S_WAIT:   if (wait_reg == WAIT_W'(TREE_LEVELS - 1)) state_next = S_COMMIT;
            S_COMMIT: if (commit_go) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        status_next = ST_OK;
        value_next  = '0;
        case (op_reg)
            OP_INSERT:
            begin
                if (top.hit)   status_next = ST_DUP;
                else if (full) status_next = ST_FULL;
            end
            OP_DELETE:
            begin
                if (!top.hit) status_next = ST_ABSENT;
            end
            OP_QUERY:
            begin
                if (rank_bad_reg) status_next = ST_RANK;
                else              value_next  = value_of(top.qv);
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_reg      <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CMP)
            begin
                wait_reg <= '0;
            end
            else if (state_reg == S_WAIT)
            begin
                wait_reg <= wait_reg + 1'b1;
            end
            if (commit_ins)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (commit_del)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (commit_go)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg       <= op_t'(req.op);
            b_reg        <= key_of(req.key);
            rank_bad_reg <= (rank_ext == '0) || (rank_ext > cnt_ext);
            tgt_reg      <= diff[IDX_BITS-1:0];
        end
        if (commit_go)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
            if (commit_ins)
            begin
                count_reg <= COUNT_W'(cnt_reg + 1'b1);
            end
            else if (commit_del)
            begin
                count_reg <= COUNT_W'(cnt_reg - 1'b1);
            end
            else
            begin
                count_reg <= COUNT_W'(cnt_reg);
            end
        end
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.value  = value_reg;
    assign rsp.status = status_reg;
    assign rsp.count  = count_reg;

    `OSS_CHECK(a_cnt_cap, 1'b1, cnt_reg <= CNT_BITS'(CAPACITY))
    `OSS_CHECK_NEXT(a_commit_out, commit_go, rsp.valid && (rsp.count == COUNT_W'(cnt_reg)))
    `OSS_CHECK_NEXT(a_ins_inc, commit_ins, cnt_reg == CNT_BITS'($past(cnt_reg) + 1'b1))
    `OSS_CHECK_NEXT(a_del_dec, commit_del, cnt_reg == CNT_BITS'($past(cnt_reg) - 1'b1))
    `OSS_CHECK(a_rank_zero, rsp.valid && (rsp.status == ST_RANK), rsp.value == '0)

endmodule

// ===== rtl/oss_cell.sv =====
module oss_cell
    import oss_pkg::*;
(
    input  logic                clk,
    input  cell_ctl_t           ctl,
    input  logic [IDX_BITS-1:0] idx,
    input  key_t                left_key,
    input  logic                left_lt,
    input  key_t                right_key,
    output key_t                key,
    output logic                lt,
    output node_t               leaf
);

    key_t  key_reg;
    logic  lt_reg;
    node_t leaf_reg;
    logic  valid;

    assign valid = CNT_BITS'(idx) < ctl.cnt;

    always_ff @(posedge clk)
    begin
        if (ctl.cmp)
        begin
            lt_reg        <= valid && (key_reg < ctl.b);
            leaf_reg.hit  <= valid && (key_reg == ctl.b);
            leaf_reg.qv   <= (valid && (idx == ctl.tgt)) ? key_reg : '0;
        end
        if (ctl.ins && !lt_reg)
        begin
            key_reg <= left_lt ? ctl.b : left_key;
        end
        else if (ctl.del && !lt_reg)
        begin
            key_reg <= right_key;
        end
    end

    assign key  = key_reg;
    assign lt   = lt_reg;
    assign leaf = leaf_reg;

endmodule

// ===== rtl/oss_or_tree.sv =====
module oss_or_tree
    import oss_pkg::*;
(
    input  logic  clk,
    input  node_t leaves [CAPACITY],
    output node_t top
);

    node_t lf [TREE_PAD];
    node_t node_reg [TREE_NODES];

    for (genvar i = 0; i < TREE_PAD; i++)
    begin : g_leaf
        if (i < CAPACITY)
        begin : g_used
            assign lf[i] = leaves[i];
        end
        else
        begin : g_pad
            assign lf[i] = '0;
        end
    end

    for (genvar l = 1; l <= TREE_LEVELS; l++)
    begin : g_lvl
        for (genvar n = 0; n < (TREE_PAD >> (RADIX_BITS * l)); n++)
        begin : g_node
            node_t acc;
            if (l == 1)
            begin : g_first
                always_comb
                begin
                    acc = '0;
                    for (int m = 0; m < RADIX; m++)
                    begin
                        acc = acc | lf[n * RADIX + m];
                    end
                end
            end
            else
            begin : g_upper
                always_comb
                begin
                    acc = '0;
                    for (int m = 0; m < RADIX; m++)
                    begin
                        acc = acc | node_reg[lvl_off(l - 1) + n * RADIX + m];
                    end
                end
            end
            always_ff @(posedge clk)
            begin
                node_reg[lvl_off(l) + n] <= acc;
            end
        end
    end

    assign top = node_reg[lvl_off(TREE_LEVELS)];

endmodule
